@@ hw/rtl/bqf_pkg.sv @@
// Shared types, formats and the sequencer program of the biquad filter unit.
package bqf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = COEF_W - 4;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int RND_W     = PROD_W + 1 - COEF_FRAC;
  localparam int NUM_COEF  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;
  localparam logic signed [PROD_W:0]   HALF_LSB = (PROD_W + 1)'(1) << (COEF_FRAC - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       clear_history;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } out_item_t;

  // Coefficient register indexes, also used as the multiplier's coefficient select.
  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_t;

  typedef enum logic {
    OP_X = 1'b0,
    OP_Y = 1'b1
  } op_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_Y,
    ACC_T_Z2,
    ACC_Z1,
    ACC_T_P,
    ACC_Z2
  } acc_op_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    coef_idx_t coef_sel;
    op_sel_t   op_sel;
    acc_op_t   acc_op;
    logic      wait_out;
    logic      last;
  } ctl_t;

  localparam step_t LAST_STEP = step_t'(5);

  // Each step issues one product and, from the second step on, folds in the product of the step before.
  function automatic ctl_t ucode(step_t step);
    ctl_t c;
    c = '{coef_sel: COEF_B0, op_sel: OP_X, acc_op: ACC_NONE, wait_out: 1'b0, last: 1'b0};
    unique case (step)
      step_t'(0): c = '{COEF_B0, OP_X, ACC_NONE, 1'b0, 1'b0};
      step_t'(1): c = '{COEF_B1, OP_X, ACC_Y,    1'b1, 1'b0};
      step_t'(2): c = '{COEF_A1, OP_Y, ACC_T_Z2, 1'b0, 1'b0};
      step_t'(3): c = '{COEF_B2, OP_X, ACC_Z1,   1'b0, 1'b0};
      step_t'(4): c = '{COEF_A2, OP_Y, ACC_T_P,  1'b0, 1'b0};
      step_t'(5): c = '{COEF_B0, OP_X, ACC_Z2,   1'b0, 1'b1};
      default:    c = '{COEF_B0, OP_X, ACC_NONE, 1'b0, 1'b1};
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/biquad_tdf2_filter_unit.sv @@
// Top level of the biquad filter unit: transposed direct form II, microcoded datapath.
//
// Usage: samples enter on the in_ channel (in_valid, in_stall, in_data) and
// filtered samples leave on the out_ channel (out_valid, out_stall, out_data).
// An item is taken at a rising edge where valid is high and stall is low.
// The five Q3.20 coefficients are written through cfg_wen, cfg_index and
// cfg_wdata (indexes b0, b1, b2, a1, a2 = 0..4; higher indexes are ignored);
// the user must write them only while idle; the unit does not enforce this.
// One shared 24x24 multiplier, stepped by a six-word program, computes the
// five products, so the unit takes no new item before it is through with
// the last one. The next item is taken in the cycle the last step runs, and
// in_stall stays high until then. The result item is written to the output
// register as the second step completes, while the delay updates finish behind it.
// If the output register still holds an untaken item when a new result is
// formed, the program holds in place until the receiver takes it, so a
// stalled receiver backs up into in_stall and nothing is lost.
// Reset (synchronous, rst_n low) clears both delay registers, loads b0 = 1.0
// and the other coefficients with zero, and empties the output register.
// An item with clear_history set is filtered with both delays zeroed.
module biquad_tdf2_filter_unit #(
  parameter int STATE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bqf_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bqf_pkg::out_item_t                out_data,
  input  logic                              cfg_wen,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bqf_pkg::COEF_W-1:0]        cfg_wdata
);

  // The accumulator covers the sum of a delay value and two rounded products.
  localparam int MAXW  = (STATE_WIDTH > bqf_pkg::RND_W) ? STATE_WIDTH : bqf_pkg::RND_W;
  localparam int ACC_W = MAXW + 2;

  localparam logic signed [ACC_W-1:0] Y_HI =
    (ACC_W'(1) << (bqf_pkg::SAMPLE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_LO = ~Y_HI;
  localparam logic signed [ACC_W-1:0] S_HI = (ACC_W'(1) << (STATE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_LO = ~S_HI;

  // Coefficient registers.
  logic signed [bqf_pkg::COEF_W-1:0]   coef_r [bqf_pkg::NUM_COEF];

  // Sequencer.
  logic                                busy_r;
  bqf_pkg::step_t                      step_r;
  bqf_pkg::ctl_t                       ctl;
  logic                                hold;
  logic                                adv;
  logic                                in_acc;

  // Datapath.
  logic signed [bqf_pkg::SAMPLE_W-1:0] x_r;
  logic signed [bqf_pkg::SAMPLE_W-1:0] y_r;
  logic signed [bqf_pkg::PROD_W-1:0]   p_r;
  logic signed [bqf_pkg::PROD_W-1:0]   prod;
  logic signed [bqf_pkg::COEF_W-1:0]   mul_a;
  logic signed [bqf_pkg::SAMPLE_W-1:0] mul_b;
  logic signed [bqf_pkg::PROD_W:0]     p_half;
  logic signed [bqf_pkg::RND_W-1:0]    p_rnd;
  logic signed [ACC_W-1:0]             rnd_ext;
  logic signed [ACC_W-1:0]             t_r;
  logic signed [ACC_W-1:0]             sum;
  logic signed [ACC_W-1:0]             y_wide;
  logic signed [ACC_W-1:0]             s_wide;
  logic                                y_clip;
  logic signed [STATE_WIDTH-1:0]       z1_r;
  logic signed [STATE_WIDTH-1:0]       z2_r;

  // Output register.
  logic                                out_valid_r;
  bqf_pkg::out_item_t                  out_data_r;

  always_comb begin
    ctl    = bqf_pkg::ucode(step_r);
    hold   = ctl.wait_out && out_valid_r && out_stall;
    adv    = busy_r && !hold;
    // A new item is taken while the unit is idle or while the last program step runs.
    in_stall = busy_r && !(adv && ctl.last);
    in_acc   = in_valid && !in_stall;
  end

  // Multiplier operands and the rounding of the previous step's product.
  always_comb begin
    mul_a   = coef_r[ctl.coef_sel];
    mul_b   = (ctl.op_sel == bqf_pkg::OP_Y) ? y_r : x_r;
    prod    = mul_a * mul_b;
    p_half  = {p_r[bqf_pkg::PROD_W-1], p_r} + bqf_pkg::HALF_LSB;
    p_rnd   = p_half[bqf_pkg::PROD_W:bqf_pkg::COEF_FRAC];
    rnd_ext = ACC_W'(p_rnd);
  end

  always_comb begin
    unique case (ctl.acc_op)
      bqf_pkg::ACC_Y:    sum = rnd_ext + ACC_W'(z1_r);
      bqf_pkg::ACC_T_Z2: sum = rnd_ext + ACC_W'(z2_r);
      bqf_pkg::ACC_Z1:   sum = t_r - rnd_ext;
      bqf_pkg::ACC_T_P:  sum = rnd_ext;
      bqf_pkg::ACC_Z2:   sum = t_r - rnd_ext;
      default:           sum = t_r;
    endcase

    y_clip = 1'b1;
    if (sum > Y_HI) begin
      y_wide = Y_HI;
    end else if (sum < Y_LO) begin
      y_wide = Y_LO;
    end else begin
      y_wide = sum;
      y_clip = 1'b0;
    end

    if (sum > S_HI) begin
      s_wide = S_HI;
    end else if (sum < S_LO) begin
      s_wide = S_LO;
    end else begin
      s_wide = sum;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[bqf_pkg::COEF_B0] <= bqf_pkg::COEF_ONE;
      coef_r[bqf_pkg::COEF_B1] <= '0;
      coef_r[bqf_pkg::COEF_B2] <= '0;
      coef_r[bqf_pkg::COEF_A1] <= '0;
      coef_r[bqf_pkg::COEF_A2] <= '0;
    end else if (cfg_wen && (cfg_index < bqf_pkg::CFG_IDX_W'(bqf_pkg::NUM_COEF))) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  // Step counter; an accepted item takes priority over the end of the program.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (adv) begin
      if (ctl.last) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + bqf_pkg::step_t'(1);
      end
    end
  end

  // Datapath registers; the clear of an accepted item overrides the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r <= '0;
      z2_r <= '0;
    end else begin
      if (adv) begin
        p_r <= prod;
        unique case (ctl.acc_op)
          bqf_pkg::ACC_Y:    y_r <= y_wide[bqf_pkg::SAMPLE_W-1:0];
          bqf_pkg::ACC_T_Z2: t_r <= sum;
          bqf_pkg::ACC_T_P:  t_r <= sum;
          default: ;
        endcase
      end
      if (in_acc) begin
        x_r <= in_data.sample_in;
      end
      if (in_acc && in_data.clear_history) begin
        z1_r <= '0;
        z2_r <= '0;
      end else if (adv && ctl.acc_op == bqf_pkg::ACC_Z1) begin
        z1_r <= s_wide[STATE_WIDTH-1:0];
      end else if (adv && ctl.acc_op == bqf_pkg::ACC_Z2) begin
        z2_r <= s_wide[STATE_WIDTH-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && ctl.acc_op == bqf_pkg::ACC_Y) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl.acc_op == bqf_pkg::ACC_Y) begin
      out_data_r.sample_out <= y_wide[bqf_pkg::SAMPLE_W-1:0];
      out_data_r.clipped    <= y_clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted item restarts the program at its first step.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> busy_r && step_r == '0)
    else $error("program did not restart on an accepted item");

  // The program counter never runs past the last step.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= bqf_pkg::LAST_STEP)
    else $error("step counter beyond program");

  // A held step keeps its place and its pending product.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && hold |=> $stable(step_r) && $stable(p_r))
    else $error("program advanced while the output was blocked");

  // A result is never written over an item the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(out_data_r))
    else $error("pending result overwritten");

  // Clearing the history zeroes both delays before the item is filtered.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.clear_history |=> z1_r == '0 && z2_r == '0)
    else $error("history clear not applied");

endmodule
